@@ sv/idl_pkg.sv @@
// Shared types, constants and format helpers of the display-list triangle assembler.
package idl_pkg;

   localparam int unsigned FMT_W           = 12;
   localparam int unsigned IDX_W           = 16;
   localparam int unsigned LOOP_W          = 4 * IDX_W;
   localparam int unsigned TRI_QUEUE_DEPTH = 4;

   localparam logic [FMT_W-1:0] FMT_RESET = 12'd8;

   localparam logic [7:0] TYPE_END   = 8'h00;
   localparam logic [7:0] TYPE_LIST  = 8'h90;
   localparam logic [7:0] TYPE_STRIP = 8'h98;

   // index_format bit positions
   localparam int unsigned FMT_POS_WIDE = 2;
   localparam int unsigned FMT_POS_HAS  = 3;
   localparam int unsigned FMT_NRM_WIDE = 4;
   localparam int unsigned FMT_NRM_HAS  = 5;
   localparam int unsigned FMT_COL_WIDE = 6;
   localparam int unsigned FMT_COL_HAS  = 7;
   localparam int unsigned FMT_UV_WIDE  = 10;
   localparam int unsigned FMT_UV_HAS   = 11;

   // attribute field codes, in stream order
   localparam logic [1:0] FIELD_POS = 2'd0;
   localparam logic [1:0] FIELD_NRM = 2'd1;
   localparam logic [1:0] FIELD_COL = 2'd2;
   localparam logic [1:0] FIELD_UV  = 2'd3;

   // primitive kinds
   localparam logic [1:0] KIND_SILENT = 2'd0;
   localparam logic [1:0] KIND_LIST   = 2'd1;
   localparam logic [1:0] KIND_STRIP  = 2'd2;

   // one assembled triangle, corners in output order
   typedef struct packed {
      logic [LOOP_W-1:0] loop0;
      logic [LOOP_W-1:0] loop1;
      logic [LOOP_W-1:0] loop2;
      logic              strip;
      logic [IDX_W-1:0]  tri_num;
   } tri_type;

   function automatic logic fmt_wide(input logic [FMT_W-1:0] fmt, input logic [1:0] f);
      logic w;
      case (f)
         FIELD_POS: w = fmt[FMT_POS_WIDE];
         FIELD_NRM: w = fmt[FMT_NRM_WIDE];
         FIELD_COL: w = fmt[FMT_COL_WIDE];
         FIELD_UV:  w = fmt[FMT_UV_WIDE];
         default:   w = 1'b0;
      endcase
      return w;
   endfunction

   // position is always read
   function automatic logic fmt_has(input logic [FMT_W-1:0] fmt, input logic [1:0] f);
      logic h;
      case (f)
         FIELD_POS: h = 1'b1;
         FIELD_NRM: h = fmt[FMT_NRM_HAS];
         FIELD_COL: h = fmt[FMT_COL_HAS];
         FIELD_UV:  h = fmt[FMT_UV_HAS];
         default:   h = 1'b0;
      endcase
      return h;
   endfunction

endpackage

@@ sv/indexed_display_list_triangle_assembler_core.sv @@
// Top level of the indexed display-list triangle assembler.
// Usage:
//  - req channel: one display-list byte per request (req_data_byte), with
//    req_buffer_last on the final byte of a geometry buffer. A request is
//    taken when req_push is high and req_full is low.
//  - rsp channel: one triangle corner per response (attribute indices,
//    corner number, strip flag, triangle ordinal, run_end on corner 2).
//    The oldest corner is shown while rsp_empty is low; rsp_pop takes it.
//  - csr channel: writes index_format; csr_ready is always high. Write it
//    only while no request is in flight.
// Timing: the parser takes one byte per cycle while req_full is low. A byte
// that completes a triangle writes it to the triangle queue at its accept
// edge, so if the queue was empty corner 0 is on the rsp ports the next
// cycle; corners 1 and 2 follow one per cycle while rsp_pop is high.
// Stalls: when rsp_pop is held low the queue fills; req_full rises once
// QUEUE_DEPTH triangles wait, and the parser holds until one drains.
// Reset clears the parser to "await type byte", empties the queue and loads
// index_format with its default.
module indexed_display_list_triangle_assembler_core #(
   parameter int unsigned QUEUE_DEPTH = idl_pkg::TRI_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_buffer_last,
   // response channel
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [idl_pkg::IDX_W-1:0] rsp_pos_idx,
   output logic [idl_pkg::IDX_W-1:0] rsp_nrm_idx,
   output logic [idl_pkg::IDX_W-1:0] rsp_col_idx,
   output logic [idl_pkg::IDX_W-1:0] rsp_tex_idx,
   output logic [1:0]                rsp_corner,
   output logic                      rsp_from_strip,
   output logic [idl_pkg::IDX_W-1:0] rsp_tri_number,
   output logic                      rsp_run_end,
   // configuration channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [idl_pkg::FMT_W-1:0] csr_index_format
);
   import idl_pkg::*;

   logic [FMT_W-1:0] fmt_ff;
   logic             req_take;
   logic             tri_valid;
   tri_type          tri_wr;
   tri_type          tri_head;
   logic             tri_empty;
   logic             tri_pop;

   // format register; writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_RESET;
      end else if (csr_valid && csr_ready) begin
         fmt_ff <= csr_index_format;
      end
   end

   // full whenever no queue slot is free, so a completing byte never drops
   assign req_take = req_push && !req_full;

   idl_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_take),
      .data_byte    (req_data_byte),
      .buffer_last  (req_buffer_last),
      .index_format (fmt_ff),
      .tri_valid    (tri_valid),
      .tri_data     (tri_wr)
   );

   idl_tri_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tri_valid),
      .wr_data (tri_wr),
      .full    (req_full),
      .rd_en   (tri_pop),
      .empty   (tri_empty),
      .rd_data (tri_head)
   );

   idl_corner_out u_corner (
      .clock          (clock),
      .reset          (reset),
      .tri_empty      (tri_empty),
      .tri_head       (tri_head),
      .tri_pop        (tri_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pos_idx    (rsp_pos_idx),
      .rsp_nrm_idx    (rsp_nrm_idx),
      .rsp_col_idx    (rsp_col_idx),
      .rsp_tex_idx    (rsp_tex_idx),
      .rsp_corner     (rsp_corner),
      .rsp_from_strip (rsp_from_strip),
      .rsp_tri_number (rsp_tri_number),
      .rsp_run_end    (rsp_run_end)
   );

   // a triangle is only produced by an accepted request
   a_tri_needs_req: assert property (@(posedge clock) disable iff (reset)
      tri_valid |-> req_take)
      else $error("triangle produced without a request");

endmodule

@@ sv/idl_parser.sv @@
// Front end: byte-stream parser that assembles vertices and triangles.
module idl_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      byte_valid,
   input  logic [7:0]                data_byte,
   input  logic                      buffer_last,
   input  logic [idl_pkg::FMT_W-1:0] index_format,
   output logic                      tri_valid,
   output idl_pkg::tri_type          tri_data
);
   import idl_pkg::*;

   localparam logic [1:0] PH_TYPE   = 2'd0;
   localparam logic [1:0] PH_CNT_HI = 2'd1;
   localparam logic [1:0] PH_CNT_LO = 2'd2;
   localparam logic [1:0] PH_VERTEX = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [1:0]        kind_ff, kind_in;
   logic [IDX_W-1:0]  verts_left_ff, verts_left_in;
   logic [IDX_W-1:0]  vert_count_ff, vert_count_in;
   logic [1:0]        vc_mod3_ff, vc_mod3_in;
   logic [IDX_W-1:0]  list_tri_ff, list_tri_in;
   logic [1:0]        field_ff, field_in;
   logic [8:0]        pend_ff, pend_in;
   logic [LOOP_W-1:0] loop_ff, loop_in;
   logic              stopped_ff, stopped_in;
   logic [LOOP_W-1:0] prior0_ff, prior0_in;
   logic [LOOP_W-1:0] prior1_ff, prior1_in;

   logic              wide;
   logic [IDX_W-1:0]  value;
   logic [LOOP_W-1:0] loop_new;
   logic [1:0]        next_field;
   logic              vert_done;
   logic [IDX_W-1:0]  strip_tri;
   logic [IDX_W-1:0]  verts_dec;

   always_comb begin
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      verts_left_in = verts_left_ff;
      vert_count_in = vert_count_ff;
      vc_mod3_in    = vc_mod3_ff;
      list_tri_in   = list_tri_ff;
      field_in      = field_ff;
      pend_in       = pend_ff;
      loop_in       = loop_ff;
      stopped_in    = stopped_ff;
      prior0_in     = prior0_ff;
      prior1_in     = prior1_ff;
      tri_valid     = 1'b0;
      tri_data      = '0;

      wide      = fmt_wide(index_format, field_ff);
      value     = wide ? {pend_ff[7:0], data_byte} : {8'd0, data_byte};
      loop_new  = loop_ff;
      loop_new[{field_ff, 4'd0} +: IDX_W] = value;
      strip_tri = vert_count_ff - IDX_W'(2);
      verts_dec = verts_left_ff - IDX_W'(1);

      vert_done  = 1'b0;
      next_field = field_ff;
      if (field_ff < FIELD_NRM && fmt_has(index_format, FIELD_NRM)) begin
         next_field = FIELD_NRM;
      end else if (field_ff < FIELD_COL && fmt_has(index_format, FIELD_COL)) begin
         next_field = FIELD_COL;
      end else if (field_ff < FIELD_UV && fmt_has(index_format, FIELD_UV)) begin
         next_field = FIELD_UV;
      end else begin
         vert_done = 1'b1;
      end

      if (byte_valid && !stopped_ff) begin
         case (phase_ff)
            PH_TYPE: begin
               if (data_byte == TYPE_END) begin
                  stopped_in = 1'b1;
               end else begin
                  kind_in  = (data_byte == TYPE_LIST)  ? KIND_LIST :
                             (data_byte == TYPE_STRIP) ? KIND_STRIP : KIND_SILENT;
                  phase_in = PH_CNT_HI;
               end
            end
            PH_CNT_HI: begin
               pend_in  = {1'b1, data_byte};
               phase_in = PH_CNT_LO;
            end
            PH_CNT_LO: begin
               verts_left_in = {pend_ff[7:0], data_byte};
               pend_in       = '0;
               vert_count_in = '0;
               vc_mod3_in    = '0;
               list_tri_in   = '0;
               field_in      = FIELD_POS;
               loop_in       = '0;
               phase_in      = ({pend_ff[7:0], data_byte} == '0) ? PH_TYPE : PH_VERTEX;
            end
            PH_VERTEX: begin
               if (wide && !pend_ff[8]) begin
                  pend_in = {1'b1, data_byte};
               end else if (!vert_done) begin
                  pend_in  = '0;
                  loop_in  = loop_new;
                  field_in = next_field;
               end else begin
                  // vertex complete: maybe release a triangle
                  if (kind_ff == KIND_LIST && vc_mod3_ff == 2'd2) begin
                     tri_valid        = 1'b1;
                     tri_data.loop0   = prior0_ff;
                     tri_data.loop1   = prior1_ff;
                     tri_data.loop2   = loop_new;
                     tri_data.strip   = 1'b0;
                     tri_data.tri_num = list_tri_ff;
                  end else if (kind_ff == KIND_STRIP && vert_count_ff >= IDX_W'(2)) begin
                     tri_valid        = 1'b1;
                     tri_data.loop0   = strip_tri[0] ? prior0_ff : prior1_ff;
                     tri_data.loop1   = strip_tri[0] ? prior1_ff : prior0_ff;
                     tri_data.loop2   = loop_new;
                     tri_data.strip   = 1'b1;
                     tri_data.tri_num = strip_tri;
                  end
                  prior0_in     = prior1_ff;
                  prior1_in     = loop_new;
                  vert_count_in = vert_count_ff + IDX_W'(1);
                  vc_mod3_in    = (vc_mod3_ff == 2'd2) ? 2'd0 : vc_mod3_ff + 2'd1;
                  list_tri_in   = (vc_mod3_ff == 2'd2) ? list_tri_ff + IDX_W'(1) : list_tri_ff;
                  verts_left_in = verts_dec;
                  loop_in       = '0;
                  field_in      = FIELD_POS;
                  pend_in       = '0;
                  if (verts_dec == '0) begin
                     phase_in = PH_TYPE;
                  end
               end
            end
            default: begin
               phase_in = PH_TYPE;
            end
         endcase
      end

      // end of geometry buffer: drop everything partial
      if (byte_valid && buffer_last) begin
         phase_in      = PH_TYPE;
         kind_in       = KIND_SILENT;
         verts_left_in = '0;
         vert_count_in = '0;
         vc_mod3_in    = '0;
         list_tri_in   = '0;
         field_in      = FIELD_POS;
         pend_in       = '0;
         loop_in       = '0;
         stopped_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TYPE;
         kind_ff       <= KIND_SILENT;
         verts_left_ff <= '0;
         vert_count_ff <= '0;
         vc_mod3_ff    <= '0;
         list_tri_ff   <= '0;
         field_ff      <= FIELD_POS;
         pend_ff       <= '0;
         loop_ff       <= '0;
         stopped_ff    <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         verts_left_ff <= verts_left_in;
         vert_count_ff <= vert_count_in;
         vc_mod3_ff    <= vc_mod3_in;
         list_tri_ff   <= list_tri_in;
         field_ff      <= field_in;
         pend_ff       <= pend_in;
         loop_ff       <= loop_in;
         stopped_ff    <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      prior0_ff <= prior0_in;
      prior1_ff <= prior1_in;
   end

   a_tri_from_vertex: assert property (@(posedge clock) disable iff (reset)
      tri_valid |-> (phase_ff == PH_VERTEX && !stopped_ff && byte_valid))
      else $error("triangle released outside vertex parsing");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (byte_valid && buffer_last) |=> (phase_ff == PH_TYPE && !stopped_ff && pend_ff == '0))
      else $error("buffer end did not clear parse state");

   a_mod3_range: assert property (@(posedge clock) disable iff (reset)
      vc_mod3_ff != 2'd3)
      else $error("list vertex phase out of range");

endmodule

@@ sv/idl_tri_fifo.sv @@
// Short triangle queue between the parser and the corner emitter.
module idl_tri_fifo #(
   parameter int unsigned DEPTH = idl_pkg::TRI_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  idl_pkg::tri_type wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic             empty,
   output idl_pkg::tri_type rd_data
);
   import idl_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tri_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("triangle queue overfilled");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("triangle queue lost a write");

endmodule

@@ sv/idl_corner_out.sv @@
// Back end: splits each queued triangle into three corner responses.
module idl_corner_out (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tri_empty,
   input  idl_pkg::tri_type          tri_head,
   output logic                      tri_pop,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic [idl_pkg::IDX_W-1:0] rsp_pos_idx,
   output logic [idl_pkg::IDX_W-1:0] rsp_nrm_idx,
   output logic [idl_pkg::IDX_W-1:0] rsp_col_idx,
   output logic [idl_pkg::IDX_W-1:0] rsp_tex_idx,
   output logic [1:0]                rsp_corner,
   output logic                      rsp_from_strip,
   output logic [idl_pkg::IDX_W-1:0] rsp_tri_number,
   output logic                      rsp_run_end
);
   import idl_pkg::*;

   logic [1:0]        corner_ff, corner_in;
   logic [LOOP_W-1:0] loop_sel;
   logic              take;

   assign rsp_empty = tri_empty;
   assign take      = rsp_pop && !tri_empty;
   assign tri_pop   = take && (corner_ff == 2'd2);

   always_comb begin
      case (corner_ff)
         2'd0:    loop_sel = tri_head.loop0;
         2'd1:    loop_sel = tri_head.loop1;
         default: loop_sel = tri_head.loop2;
      endcase
      corner_in = corner_ff;
      if (take) begin
         corner_in = (corner_ff == 2'd2) ? 2'd0 : corner_ff + 2'd1;
      end
   end

   assign rsp_pos_idx    = loop_sel[0*IDX_W +: IDX_W];
   assign rsp_nrm_idx    = loop_sel[1*IDX_W +: IDX_W];
   assign rsp_col_idx    = loop_sel[2*IDX_W +: IDX_W];
   assign rsp_tex_idx    = loop_sel[3*IDX_W +: IDX_W];
   assign rsp_corner     = corner_ff;
   assign rsp_from_strip = tri_head.strip;
   assign rsp_tri_number = tri_head.tri_num;
   assign rsp_run_end    = (corner_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= 2'd0;
      end else begin
         corner_ff <= corner_in;
      end
   end

   a_corner_range: assert property (@(posedge clock) disable iff (reset)
      corner_ff != 2'd3)
      else $error("corner counter out of range");

   a_corner_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(corner_ff))
      else $error("corner advanced without a pop");

endmodule
